[hdl/sfc_pkg.sv]
package sfc_pkg;

   localparam int FRAC_BITS        = 16;
   localparam int WORD_W           = 32;
   localparam int NUM_PLANES       = 6;
   localparam int PIDX_W           = 3;
   localparam int VIS_W            = 2;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_W           = 1;
   localparam int QCNT_W           = 2;

   localparam logic [PIDX_W-1:0] FIRST_PLANE      = PIDX_W'(0);
   localparam logic [PIDX_W-1:0] FIRST_SIDE_PLANE = PIDX_W'(2);
   localparam logic [PIDX_W-1:0] LAST_PLANE       = PIDX_W'(NUM_PLANES - 1);

   // request kinds as carried on the channel
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // visibility codes
   localparam logic [VIS_W-1:0] VIS_OUTSIDE = 2'd0;
   localparam logic [VIS_W-1:0] VIS_PARTIAL = 2'd1;
   localparam logic [VIS_W-1:0] VIS_INSIDE  = 2'd2;

   // queued command: loads carry nx, ny, nz, d; queries carry cx, cy, cz, r
   typedef struct packed {
      logic                     op;
      logic [PIDX_W-1:0]        idx;
      logic signed [WORD_W-1:0] w0;
      logic signed [WORD_W-1:0] w1;
      logic signed [WORD_W-1:0] w2;
      logic signed [WORD_W-1:0] w3;
   } cmd_type;

   typedef struct packed {
      logic [VIS_W-1:0]      vis;
      logic [NUM_PLANES-1:0] flags;
   } res_type;

endpackage

[hdl/sfc_if.sv]
interface sfc_req_if import sfc_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [PIDX_W-1:0]        plane_index;
   logic signed [WORD_W-1:0] normal_x;
   logic signed [WORD_W-1:0] normal_y;
   logic signed [WORD_W-1:0] normal_z;
   logic signed [WORD_W-1:0] plane_offset;
   logic signed [WORD_W-1:0] centre_x;
   logic signed [WORD_W-1:0] centre_y;
   logic signed [WORD_W-1:0] centre_z;
   logic signed [WORD_W-1:0] radius;
   logic                     skip_near_far;

   modport source (
      output valid, req_type, plane_index, normal_x, normal_y, normal_z, plane_offset,
             centre_x, centre_y, centre_z, radius, skip_near_far,
      input  ready
   );
   modport sink (
      input  valid, req_type, plane_index, normal_x, normal_y, normal_z, plane_offset,
             centre_x, centre_y, centre_z, radius, skip_near_far,
      output ready
   );
endinterface

interface sfc_rsp_if import sfc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [VIS_W-1:0]      visibility;
   logic [NUM_PLANES-1:0] clip_mask;

   modport source (output valid, visibility, clip_mask, input ready);
   modport sink   (input valid, visibility, clip_mask, output ready);
endinterface

[hdl/sfc_front.sv]
module sfc_front import sfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   sfc_req_if.sink       req,
   output logic          cmd_valid,
   input  logic          cmd_ready,
   output cmd_type       cmd_data
);

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             cmd_new;
   logic                accept;
   logic                drop;
   logic                push;
   logic                pop;

   // classify: queries pick their first plane, loads beyond the table are dropped
   always_comb begin
      cmd_new.op  = req.req_type;
      if (req.req_type == OP_QUERY) begin
         cmd_new.idx = req.skip_near_far ? FIRST_SIDE_PLANE : FIRST_PLANE;
         cmd_new.w0  = req.centre_x;
         cmd_new.w1  = req.centre_y;
         cmd_new.w2  = req.centre_z;
         cmd_new.w3  = req.radius;
      end else begin
         cmd_new.idx = req.plane_index;
         cmd_new.w0  = req.normal_x;
         cmd_new.w1  = req.normal_y;
         cmd_new.w2  = req.normal_z;
         cmd_new.w3  = req.plane_offset;
      end
   end

   assign req.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign accept    = req.valid && req.ready;
   assign drop      = (req.req_type == OP_LOAD) && (req.plane_index > LAST_PLANE);
   assign push      = accept && !drop;
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue did not grow on push");

   a_drop_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && drop && !pop) |=> $stable(count_ff))
      else $error("dropped load changed the queue");

endmodule

[hdl/sfc_back.sv]
module sfc_back import sfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    res_valid,
   input  logic    res_ready,
   output res_type res_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic signed [WORD_W-1:0]   nx_ff [NUM_PLANES];
   logic signed [WORD_W-1:0]   ny_ff [NUM_PLANES];
   logic signed [WORD_W-1:0]   nz_ff [NUM_PLANES];
   logic signed [WORD_W-1:0]   d_ff  [NUM_PLANES];
   logic [PIDX_W-1:0]          plane_ff, plane_in;
   logic signed [WORD_W-1:0]   cx_ff, cx_in;
   logic signed [WORD_W-1:0]   cy_ff, cy_in;
   logic signed [WORD_W-1:0]   cz_ff, cz_in;
   logic signed [WORD_W-1:0]   r_ff, r_in;
   logic signed [2*WORD_W-1:0] px_ff, px_in;
   logic signed [2*WORD_W-1:0] py_ff, py_in;
   logic signed [2*WORD_W-1:0] pz_ff, pz_in;
   logic [VIS_W-1:0]           vis_ff, vis_in;
   logic [NUM_PLANES-1:0]      flags_ff, flags_in;
   logic                       load_en;
   logic signed [WORD_W-1:0]   plane_dist;
   logic signed [WORD_W:0]     neg_r;
   logic                       reject;
   logic                       straddle;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign load_en   = cmd_valid && cmd_ready && (cmd_data.op == OP_LOAD);
   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = '{vis: vis_ff, flags: flags_ff};

   // wrapped Q-format sum of the three shifted products and the offset
   always_comb begin
      plane_dist = px_ff[FRAC_BITS +: WORD_W] + py_ff[FRAC_BITS +: WORD_W]
                 + pz_ff[FRAC_BITS +: WORD_W] + d_ff[plane_ff];
      neg_r    = -$signed({r_ff[WORD_W-1], r_ff});
      reject   = (plane_dist >= r_ff);
      straddle = ($signed({plane_dist[WORD_W-1], plane_dist}) > neg_r);
   end

   always_comb begin
      state_in = state_ff;
      plane_in = plane_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      r_in     = r_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      pz_in    = pz_ff;
      vis_in   = vis_ff;
      flags_in = flags_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_data.op == OP_QUERY) begin
               plane_in = cmd_data.idx;
               cx_in    = cmd_data.w0;
               cy_in    = cmd_data.w1;
               cz_in    = cmd_data.w2;
               r_in     = cmd_data.w3;
               vis_in   = VIS_INSIDE;
               flags_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            px_in    = nx_ff[plane_ff] * cx_ff;
            py_in    = ny_ff[plane_ff] * cy_ff;
            pz_in    = nz_ff[plane_ff] * cz_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (reject) begin
               vis_in   = VIS_OUTSIDE;
               state_in = ST_DONE;
            end else begin
               if (straddle) begin
                  vis_in   = VIS_PARTIAL;
                  flags_in = flags_ff | (NUM_PLANES'(1) << plane_ff);
               end
               if (plane_ff == LAST_PLANE) begin
                  state_in = ST_DONE;
               end else begin
                  plane_in = plane_ff + PIDX_W'(1);
                  state_in = ST_MUL;
               end
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < NUM_PLANES; i++) begin
            nx_ff[i] <= '0;
            ny_ff[i] <= '0;
            nz_ff[i] <= '0;
            d_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (load_en) begin
            nx_ff[cmd_data.idx] <= cmd_data.w0;
            ny_ff[cmd_data.idx] <= cmd_data.w1;
            nz_ff[cmd_data.idx] <= cmd_data.w2;
            d_ff[cmd_data.idx]  <= cmd_data.w3;
         end
      end
   end

   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      r_ff     <= r_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
      vis_ff   <= vis_in;
      flags_ff <= flags_in;
   end

   a_mul_then_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (state_ff == ST_SUM))
      else $error("product stage not followed by sum stage");

   a_last_plane_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && plane_ff == LAST_PLANE) |=> (state_ff == ST_DONE))
      else $error("query ran past the last plane");

   a_inside_no_flags: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && vis_ff == VIS_INSIDE) |-> (flags_ff == '0))
      else $error("inside result carries clip flags");

   a_handoff_idle: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after result handoff");

endmodule

[hdl/sphere_frustum_cull_unit.sv]
// Sphere against six-plane frustum classifier.
//
// req_ch carries two kinds of request. A load (req_type 0) writes one plane
// (normal and offset, signed Q16.16) into the six-entry plane table; loads
// with a plane index above five are dropped, and loads give no response. A
// query (req_type 1) tests a sphere and gives one response on rsp_ch with
// visibility (0 outside, 1 partial, 2 inside) and one clip flag per plane.
//
// The front end classifies requests into a two-entry command queue; the back
// end sequencer runs one command at a time and reuses one set of three
// 32x32 multipliers, testing each plane as products, then sum and compare,
// and stopping at the first rejecting plane. A query passes from the queue
// through the sequencer's product and sum states, once per tested plane,
// then its done state, which hands the result over, and the output register
// to rsp_ch. The sequencer returns to idle between commands and takes a
// command only there; a load is written in the idle state and leaves the
// sequencer idle.
//
// Reset clears the plane table to zero and empties the queue. When rsp_ch
// stalls, the response holds in the output register, the sequencer waits
// with the next result, and the queue keeps accepting until it is full.
module sphere_frustum_cull_unit import sfc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sfc_req_if.sink   req_ch,
   sfc_rsp_if.source rsp_ch
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_data;
   logic    res_valid;
   logic    res_ready;
   res_type res_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VIS_W-1:0]      rsp_vis_ff, rsp_vis_in;
   logic [NUM_PLANES-1:0] rsp_flags_ff, rsp_flags_in;

   // accept and classify requests
   sfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   // run loads and plane tests
   sfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   // output register: take a new result whenever the slot is empty or draining
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_vis_in   = rsp_vis_ff;
      rsp_flags_in = rsp_flags_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_vis_in   = res_data.vis;
            rsp_flags_in = res_data.flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_vis_ff   <= rsp_vis_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.visibility = rsp_vis_ff;
   assign rsp_ch.clip_mask  = rsp_flags_ff;

endmodule

[tb/tb_sphere_frustum_cull_unit.sv]
module tb_sphere_frustum_cull_unit;
   import sfc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD   = 20;
   localparam int TIMEOUT_CYCLES = 500_000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_ITEMS    = 396;
   localparam int MAX_REPORTS    = 50;
   localparam int ONE            = 1 << FRAC_BITS;   // 1.0 in Q16.16

   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

   // One request as held in the stimulus table. Fields that the request kind
   // does not use still carry random values, so every input bit toggles.
   // has_preset marks a query whose response is written in by hand.
   typedef struct {
      logic                     kind;
      logic [PIDX_W-1:0]        idx;
      logic signed [WORD_W-1:0] nx;
      logic signed [WORD_W-1:0] ny;
      logic signed [WORD_W-1:0] nz;
      logic signed [WORD_W-1:0] d;
      logic signed [WORD_W-1:0] cx;
      logic signed [WORD_W-1:0] cy;
      logic signed [WORD_W-1:0] cz;
      logic signed [WORD_W-1:0] r;
      logic                     skip;
      bit                       has_preset;
      res_type                  want;
   } stim_row_type;

   logic clock;
   logic reset;

   sfc_req_if req_ch ();
   sfc_rsp_if rsp_ch ();

   sphere_frustum_cull_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the plane table, cleared as the block clears it at reset.
   logic signed [WORD_W-1:0] shadow_nx [NUM_PLANES] = '{default: '0};
   logic signed [WORD_W-1:0] shadow_ny [NUM_PLANES] = '{default: '0};
   logic signed [WORD_W-1:0] shadow_nz [NUM_PLANES] = '{default: '0};
   logic signed [WORD_W-1:0] shadow_d  [NUM_PLANES] = '{default: '0};

   // Verdicts still owed by the block, oldest first.
   res_type awaited_results [$];

   int send_idle_pct    = 0;
   int recv_stall_pct   = 0;
   bit hold_off_request = 1'b0;

   int n_sent    = 0;   // requests that the block acts on
   int n_loads   = 0;
   int n_dropped = 0;   // loads to plane six or seven
   int n_queries = 0;
   int n_outside = 0;
   int n_partial = 0;
   int n_inside  = 0;
   int n_errors  = 0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run, even with every query
   // walking all six planes behind a stalling receiver.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("sphere_frustum_cull_unit verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // One Q16.16 product: exact in 64 bits, arithmetic shift back (floors),
   // then wrap to the word width.
   function automatic logic [WORD_W-1:0] scaled_product(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
      logic signed [63:0] wide_a;
      logic signed [63:0] wide_b;
      logic signed [63:0] prod;
      wide_a = a;
      wide_b = b;
      prod   = wide_a * wide_b;
      prod   = prod >>> FRAC_BITS;
      return prod[WORD_W-1:0];
   endfunction

   // Walk the tested planes in order; the first plane at or beyond the radius
   // rejects the sphere, and planes closer than the radius on either side
   // are straddled and flagged.
   function automatic res_type classify_sphere(input logic signed [WORD_W-1:0] cx,
                                               input logic signed [WORD_W-1:0] cy,
                                               input logic signed [WORD_W-1:0] cz,
                                               input logic signed [WORD_W-1:0] r,
                                               input logic                     skip);
      res_type                  verdict;
      logic [WORD_W-1:0]        acc;
      logic signed [WORD_W-1:0] plane_dist;
      logic signed [WORD_W:0]   neg_r;
      int                       first;
      verdict.vis   = VIS_INSIDE;
      verdict.flags = '0;
      // negate in one extra bit so that the most negative radius stays exact
      neg_r = r;
      neg_r = -neg_r;
      first = skip ? int'(FIRST_SIDE_PLANE) : int'(FIRST_PLANE);
      for (int p = first; p < NUM_PLANES; p++) begin
         acc  = scaled_product(shadow_nx[p], cx) + scaled_product(shadow_ny[p], cy)
              + scaled_product(shadow_nz[p], cz) + shadow_d[p];
         plane_dist = acc;
         if (plane_dist >= r) begin
            verdict.vis = VIS_OUTSIDE;
            break;
         end
         if (plane_dist > neg_r) begin
            verdict.vis      = VIS_PARTIAL;
            verdict.flags[p] = 1'b1;
         end
      end
      return verdict;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Random word, biased towards the corners of the signed range.
   function automatic logic signed [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 15))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2:       return '0;
         3:       return -1;
         default: return $urandom();
      endcase
   endfunction

   function automatic int spread(input int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   function automatic stim_row_type load_row(input int idx, input int nx, input int ny,
                                             input int nz, input int d);
      stim_row_type row;
      row.kind       = OP_LOAD;
      row.idx        = PIDX_W'(idx);
      row.nx         = nx;
      row.ny         = ny;
      row.nz         = nz;
      row.d          = d;
      row.cx         = $urandom();
      row.cy         = $urandom();
      row.cz         = $urandom();
      row.r          = $urandom();
      row.skip       = 1'($urandom_range(0, 1));
      row.has_preset = 1'b0;
      row.want       = '0;
      return row;
   endfunction

   function automatic stim_row_type query_row(input int cx, input int cy, input int cz,
                                              input int r, input logic skip);
      stim_row_type row;
      row.kind       = OP_QUERY;
      row.idx        = PIDX_W'($urandom_range(0, 7));
      row.nx         = $urandom();
      row.ny         = $urandom();
      row.nz         = $urandom();
      row.d          = $urandom();
      row.cx         = cx;
      row.cy         = cy;
      row.cz         = cz;
      row.r          = r;
      row.skip       = skip;
      row.has_preset = 1'b0;
      row.want       = '0;
      return row;
   endfunction

   function automatic stim_row_type preset_query(input int cx, input int cy, input int cz,
                                                 input int r, input logic skip,
                                                 input logic [VIS_W-1:0] vis,
                                                 input logic [NUM_PLANES-1:0] flags);
      stim_row_type row;
      row            = query_row(cx, cy, cz, r, skip);
      row.has_preset = 1'b1;
      row.want.vis   = vis;
      row.want.flags = flags;
      return row;
   endfunction

   // Offer one request, idling first at the phase's rate, and hold it until
   // the block takes it. Update the shadow table or log the owed verdict on
   // the very edge at which the request is accepted.
   task automatic send_request(input stim_row_type row);
      res_type verdict;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= row.kind;
      req_ch.plane_index   <= row.idx;
      req_ch.normal_x      <= row.nx;
      req_ch.normal_y      <= row.ny;
      req_ch.normal_z      <= row.nz;
      req_ch.plane_offset  <= row.d;
      req_ch.centre_x      <= row.cx;
      req_ch.centre_y      <= row.cy;
      req_ch.centre_z      <= row.cz;
      req_ch.radius        <= row.r;
      req_ch.skip_near_far <= row.skip;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (row.kind == OP_LOAD) begin
         if (row.idx < NUM_PLANES) begin
            shadow_nx[row.idx] = row.nx;
            shadow_ny[row.idx] = row.ny;
            shadow_nz[row.idx] = row.nz;
            shadow_d[row.idx]  = row.d;
            n_loads++;
            n_sent++;
         end else begin
            n_dropped++;
         end
      end else begin
         if (row.has_preset) verdict = row.want;
         else verdict = classify_sphere(row.cx, row.cy, row.cz, row.r, row.skip);
         awaited_results.push_back(verdict);
         n_queries++;
         n_sent++;
      end
   endtask

   // Load a plausible box-shaped frustum (outward normals near unit length,
   // slightly tilted) in shuffled plane order, then test spheres scattered
   // around it. With fewer than six planes the set is left half built and
   // the older planes stay in force.
   task automatic send_frustum_set(input int n_planes, input int n_spheres);
      int half [3];
      int order [NUM_PLANES];
      int n [3];
      int c [3];
      int axis;
      int pick;
      int tmp;
      int r;
      for (int k = 0; k < 3; k++) half[k] = $urandom_range(ONE, 300 * ONE);
      for (int i = 0; i < NUM_PLANES; i++) order[i] = i;
      for (int i = NUM_PLANES - 1; i > 0; i--) begin
         pick        = $urandom_range(0, i);
         tmp         = order[i];
         order[i]    = order[pick];
         order[pick] = tmp;
      end
      for (int i = 0; i < n_planes; i++) begin
         // near and far face along z, then the x pair, then the y pair
         axis = (order[i] < 2) ? 2 : (order[i] < 4) ? 0 : 1;
         for (int k = 0; k < 3; k++) n[k] = spread(2048);
         n[axis] = ONE + spread(4096);
         if (order[i] == 0 || order[i] == 3 || order[i] == 5) n[axis] = -n[axis];
         send_request(load_row(order[i], n[0], n[1], n[2],
                               -half[axis] + spread(ONE / 4)));
      end
      for (int q = 0; q < n_spheres; q++) begin
         for (int k = 0; k < 3; k++) c[k] = int'($urandom_range(0, 4 * half[k])) - 2 * half[k];
         case ($urandom_range(0, 9))
            0:       r = 0;
            1:       r = -int'($urandom_range(1, 4 * ONE));
            2:       r = rand_word();
            default: r = $urandom_range(0, half[$urandom_range(0, 2)]);
         endcase
         send_request(query_row(c[0], c[1], c[2], r, 1'($urandom_range(0, 1))));
      end
   endtask

   // Noise: a load anywhere in the index range or a query with any values.
   task automatic send_noise();
      if ($urandom_range(0, 1))
         send_request(load_row($urandom_range(0, 7), rand_word(), rand_word(),
                               rand_word(), rand_word()));
      else
         send_request(query_row(rand_word(), rand_word(), rand_word(), rand_word(),
                                1'($urandom_range(0, 1))));
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // Stall at the phase's rate; on request, hold off for a long stretch so
   // that the command queue fills and the block pushes back on requests.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Compare each delivered verdict with the oldest one owed.
   always @(posedge clock) begin : verdict_check
      res_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         case (rsp_ch.visibility)
            VIS_OUTSIDE: n_outside++;
            VIS_PARTIAL: n_partial++;
            VIS_INSIDE:  n_inside++;
            default:     ;
         endcase
         if (awaited_results.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
               $error("response with no query outstanding: visibility %0d clip_mask %b",
                      rsp_ch.visibility, rsp_ch.clip_mask);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_ch.visibility !== want.vis) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $error("visibility: expected %0d, actual %0d", want.vis, rsp_ch.visibility);
            end
            if (rsp_ch.clip_mask !== want.flags) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $error("clip_mask: expected %b, actual %b", want.flags, rsp_ch.clip_mask);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin : stimulus
      stim_row_type directed_rows [$];
      int           target;
      int           pick;
      int           h;

      // drive every input to a known value before the first edge
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.req_type      <= OP_LOAD;
      req_ch.plane_index   <= '0;
      req_ch.normal_x      <= '0;
      req_ch.normal_y      <= '0;
      req_ch.normal_z      <= '0;
      req_ch.plane_offset  <= '0;
      req_ch.centre_x      <= '0;
      req_ch.centre_y      <= '0;
      req_ch.centre_z      <= '0;
      req_ch.radius        <= '0;
      req_ch.skip_near_far <= 1'b0;

      h = 10 * ONE;

      // Directed table. With the table cleared every distance is zero, so
      // the first rows have verdicts that can be written in directly.
      // zero table, positive radius: every tested plane straddled
      directed_rows.push_back(preset_query(0, 0, 0, ONE, 1'b0, VIS_PARTIAL, 6'b111111));
      // zero radius: rejected by the first plane, no flags
      directed_rows.push_back(preset_query(WORD_MAX, WORD_MIN, -1, 0, 1'b0,
                                           VIS_OUTSIDE, 6'b000000));
      // most negative radius: distance zero is already beyond it
      directed_rows.push_back(preset_query(0, 0, 0, WORD_MIN, 1'b1, VIS_OUTSIDE, 6'b000000));
      // largest radius, near and far skipped: only the side flags
      directed_rows.push_back(preset_query(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1,
                                           VIS_PARTIAL, 6'b111100));
      // small negative radius
      directed_rows.push_back(preset_query(WORD_MIN, WORD_MIN, WORD_MIN, -1, 1'b0,
                                           VIS_OUTSIDE, 6'b000000));
      // loads to plane six and seven must be dropped
      directed_rows.push_back(load_row(6, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
      directed_rows.push_back(load_row(7, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
      directed_rows.push_back(preset_query(ONE, ONE, ONE, ONE, 1'b1, VIS_PARTIAL, 6'b111100));
      // unit box of half size ten: near, far, +x, -x, +y, -y
      directed_rows.push_back(load_row(0, 0, 0, -ONE, -h));
      directed_rows.push_back(load_row(1, 0, 0, ONE, -h));
      directed_rows.push_back(load_row(2, ONE, 0, 0, -h));
      directed_rows.push_back(load_row(3, -ONE, 0, 0, -h));
      directed_rows.push_back(load_row(4, 0, ONE, 0, -h));
      directed_rows.push_back(load_row(5, 0, -ONE, 0, -h));
      // wholly inside, straddling +x, beyond +x
      directed_rows.push_back(query_row(0, 0, 0, ONE, 1'b0));
      directed_rows.push_back(query_row(h - ONE / 2, 0, 0, ONE, 1'b0));
      directed_rows.push_back(query_row(2 * h, 0, 0, ONE, 1'b0));
      // straddles near, then rejected by -x: keep only the flags before it
      directed_rows.push_back(query_row(-h - 5 * ONE, 0, -h - ONE / 2, ONE, 1'b0));
      // well beyond near but near and far skipped
      directed_rows.push_back(query_row(0, 0, -2 * h, ONE, 1'b1));
      // extreme plane: products wrap after the shift
      directed_rows.push_back(load_row(5, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX));
      directed_rows.push_back(query_row(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN, 1'b0));
      directed_rows.push_back(query_row(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 1'b1));
      directed_rows.push_back(query_row(0, 0, 0, -5 * ONE, 1'b0));
      // tiny negative products must round towards minus infinity
      directed_rows.push_back(load_row(5, -1, -1, -1, 0));
      directed_rows.push_back(query_row(1, 1, 1, ONE, 1'b1));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      // Random part in four idling phases; a long receiver hold-off follows
      // the first so the queue fills while requests keep coming.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         target = n_sent + PHASE_ITEMS;
         while (n_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
               send_frustum_set(NUM_PLANES, $urandom_range(4, 16));
            else if (pick < 88)
               send_frustum_set($urandom_range(1, NUM_PLANES - 1), $urandom_range(2, 8));
            else
               repeat ($urandom_range(1, 4)) send_noise();
         end
         if (phase == 0) begin
            hold_off_request = 1'b1;
            send_frustum_set(NUM_PLANES, 40);
         end
      end

      // release the channel and let every owed verdict arrive
      req_ch.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d plane loads (%0d more dropped for a bad index), %0d sphere queries",
               n_loads, n_dropped, n_queries);
      $display("verdicts seen: %0d outside, %0d partial, %0d inside; %0d mismatches",
               n_outside, n_partial, n_inside, n_errors);
      if (n_errors == 0) begin
         $display("sphere_frustum_cull_unit verification clean");
      end else begin
         $display("sphere_frustum_cull_unit verification failed");
      end
      $finish;
   end

endmodule

[files.f]
hdl/sfc_pkg.sv
hdl/sfc_if.sv
hdl/sfc_front.sv
hdl/sfc_back.sv
hdl/sphere_frustum_cull_unit.sv
tb/tb_sphere_frustum_cull_unit.sv
